// File: hdl/sdspi_pkg.sv
// Shared types, codes and constants of the SD card SPI-mode host engine.
package sdspi_pkg;

    // Default sizes.
    localparam int BLOCK_BYTES_DEF = 512;
    localparam int CSD_BYTES       = 16;
    localparam int RES_Q_DEPTH_DEF = 4;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_IDX_W       = 3;

    // Input item codes.
    localparam logic [1:0] C_REQ   = 2'd0;
    localparam logic [1:0] C_CARD  = 2'd1;
    localparam logic [1:0] C_WBYTE = 2'd2;

    // Host request codes.
    localparam logic [1:0] RQ_INIT  = 2'd0;
    localparam logic [1:0] RQ_READ  = 2'd1;
    localparam logic [1:0] RQ_WRITE = 2'd2;
    localparam logic [1:0] RQ_CAP   = 2'd3;

    // Result kinds.
    localparam logic [1:0] K_EXCH  = 2'd0;
    localparam logic [1:0] K_RDATA = 2'd1;
    localparam logic [1:0] K_DONE  = 2'd2;
    localparam logic [1:0] K_NEED  = 2'd3;

    // Completion status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_R1_ERR   = 3'd1;
    localparam logic [2:0] ST_NO_RESP  = 3'd2;
    localparam logic [2:0] ST_TOKEN_TO = 3'd3;
    localparam logic [2:0] ST_WR_REJ   = 3'd4;
    localparam logic [2:0] ST_BUSY_TO  = 3'd5;
    localparam logic [2:0] ST_UNKNOWN  = 3'd6;

    // Card kinds.
    localparam logic [2:0] CK_NONE = 3'd0;
    localparam logic [2:0] CK_SD1  = 3'd1;
    localparam logic [2:0] CK_MMC  = 3'd2;
    localparam logic [2:0] CK_SD2  = 3'd3;
    localparam logic [2:0] CK_SDHC = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POLL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BUSY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE  = 3'd5;

    // Protocol bytes.
    localparam logic [7:0] B_IDLE   = 8'hFF;
    localparam logic [7:0] B_TOKEN  = 8'hFE;
    localparam logic [7:0] R1_IDLE  = 8'h01;
    localparam logic [7:0] R1_ILL5  = 8'h05;
    localparam logic [7:0] R1_ILL9  = 8'h09;
    localparam logic [4:0] DRESP_OK = 5'h05;

    // Command phases, one-hot.
    typedef enum logic [16:0] {
        PH_IDLE  = 17'h00001, PH_WAKE  = 17'h00002, PH_CMD   = 17'h00004,
        PH_POLL  = 17'h00008, PH_REL   = 17'h00010, PH_R7    = 17'h00020,
        PH_R7REL = 17'h00040, PH_TOKEN = 17'h00080, PH_RDATA = 17'h00100,
        PH_RCRC  = 17'h00200, PH_FIN   = 17'h00400, PH_WPRE  = 17'h00800,
        PH_WNEED = 17'h01000, PH_WDATA = 17'h02000, PH_WCRC  = 17'h04000,
        PH_WRESP = 17'h08000, PH_BUSY  = 17'h10000
    } t_phase;

    // Command in flight.
    typedef enum logic [3:0] {
        W_NONE, W_CMD0, W_CMD8, W_CMD55A, W_ACMD41A, W_CMD1, W_CMD55B,
        W_ACMD41B, W_CMD58, W_CMD17, W_CMD9, W_CMD24
    } t_which;

    // One result beat.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic        chip_select;
        logic [7:0]  read_data;
        logic [2:0]  status;
        logic [7:0]  card_r1;
        logic [2:0]  card_kind;
        logic [33:0] capacity_kb;
        logic        last;
    } t_res;

    // Results produced by one input beat.
    typedef struct packed {
        logic [1:0] count;
        t_res       res0;
        t_res       res1;
    } t_res_pair;

endpackage

// File: hdl/sdspi_engine.sv
// Front part: accepts input beats, runs the card protocol and emits result beats.
module sdspi_engine #(
    parameter int BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [1:0]                       i_cmd,
    input  logic [1:0]                       i_request,
    input  logic [31:0]                      i_block_address,
    input  logic [7:0]                       i_rx_byte,
    input  logic [7:0]                       i_write_byte,
    input  logic                             i_cfg_we,
    input  logic [sdspi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sdspi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output sdspi_pkg::t_res_pair             o_res
);
    import sdspi_pkg::*;

    localparam int BC_W = ($clog2(BLOCK_BYTES + 1) > 9) ? $clog2(BLOCK_BYTES + 1) : 9;
    localparam logic [BC_W-1:0] BLK_N = BC_W'(BLOCK_BYTES);
    localparam logic [BC_W-1:0] CSD_N = BC_W'(CSD_BYTES);

    // Configuration registers.
    logic [7:0]  r_poll_lim;
    logic [9:0]  r_idle_lim;
    logic [15:0] r_opc_lim;
    logic [15:0] r_token_lim;
    logic [15:0] r_busy_lim;
    logic [7:0]  r_wake_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_lim  <= 8'd200;
            r_idle_lim  <= 10'd200;
            r_opc_lim   <= 16'd2000;
            r_token_lim <= 16'd4095;
            r_busy_lim  <= 16'd40000;
            r_wake_cnt  <= 8'd11;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POLL:  r_poll_lim  <= i_cfg_data[7:0];
                CFG_IDLE:  r_idle_lim  <= i_cfg_data[9:0];
                CFG_OPC:   r_opc_lim   <= i_cfg_data;
                CFG_TOKEN: r_token_lim <= i_cfg_data;
                CFG_BUSY:  r_busy_lim  <= i_cfg_data;
                CFG_WAKE:  r_wake_cnt  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Protocol state.
    t_phase            r_phase, n_phase;
    t_which            r_which, n_which;
    logic [BC_W-1:0]   r_bc, n_bc;
    logic [15:0]       r_retry, n_retry;
    logic [47:0]       r_frame, n_frame;
    logic [31:0]       r_shift, n_shift;
    logic [2:0]        r_kind, n_kind;
    logic [7:0]        r_last_r, n_last_r;

    // Step-local signals.
    logic [BC_W-1:0] bc_inc;
    logic [16:0]     retry_inc;
    logic            do_start, do_resp, ex_v, ex_cs, rd_v, need_v, done_v;
    t_which          st_which;
    logic [5:0]      st_idx;
    logic [31:0]     st_arg;
    logic [7:0]      st_crc, ex_tx, resp, rd_data;
    logic [2:0]      done_st;
    logic [33:0]     done_cap;
    logic [24:0]     cap_sum;
    t_res            rd_beat, tail_beat;
    logic            is_release;

    assign bc_inc    = r_bc + 1'b1;
    assign retry_inc = {1'b0, r_retry} + 17'd1;
    assign cap_sum   = {1'b0, r_shift[23:0]} + 25'd1;

    always_comb begin
        n_phase  = r_phase;
        n_which  = r_which;
        n_bc     = r_bc;
        n_retry  = r_retry;
        n_frame  = r_frame;
        n_shift  = r_shift;
        n_kind   = r_kind;
        n_last_r = r_last_r;
        do_start = 1'b0;
        do_resp  = 1'b0;
        st_which = W_NONE;
        st_idx   = 6'd0;
        st_arg   = 32'd0;
        st_crc   = 8'd0;
        resp     = 8'd0;
        ex_v     = 1'b0;
        ex_tx    = B_IDLE;
        ex_cs    = 1'b0;
        rd_v     = 1'b0;
        rd_data  = 8'd0;
        need_v   = 1'b0;
        done_v   = 1'b0;
        done_st  = ST_OK;
        done_cap = 34'd0;
        is_release = (r_which == W_CMD0) || (r_which == W_CMD55A) ||
                     (r_which == W_ACMD41A) || (r_which == W_CMD1) ||
                     (r_which == W_CMD55B) || (r_which == W_ACMD41B);

        // Decode the input beat.
        if (i_valid) begin
            unique case (i_cmd)
                C_REQ: begin
                    if (r_phase == PH_IDLE) begin
                        n_retry = 16'd0;
                        n_bc    = '0;
                        unique case (i_request)
                            RQ_INIT: begin
                                n_kind  = CK_NONE;
                                n_which = W_NONE;
                                if (r_wake_cnt == 8'd0) begin
                                    do_start = 1'b1; st_which = W_CMD0;
                                    st_idx = 6'd0; st_crc = 8'h95;
                                end else begin
                                    n_phase = PH_WAKE;
                                    ex_v = 1'b1;
                                end
                            end
                            RQ_READ: begin
                                do_start = 1'b1; st_which = W_CMD17;
                                st_idx = 6'd17; st_arg = i_block_address;
                            end
                            RQ_WRITE: begin
                                do_start = 1'b1; st_which = W_CMD24;
                                st_idx = 6'd24; st_arg = i_block_address;
                            end
                            default: begin
                                do_start = 1'b1; st_which = W_CMD9;
                                st_idx = 6'd9; st_crc = 8'hFF;
                            end
                        endcase
                    end
                end
                C_CARD: begin
                    unique case (r_phase)
                        PH_WAKE: begin
                            n_bc = bc_inc;
                            if (bc_inc < BC_W'(r_wake_cnt)) begin
                                ex_v = 1'b1;
                            end else begin
                                do_start = 1'b1; st_which = W_CMD0;
                                st_idx = 6'd0; st_crc = 8'h95;
                            end
                        end
                        PH_CMD: begin
                            n_bc = bc_inc;
                            if (bc_inc < BC_W'(2)) begin
                                ex_v = 1'b1;
                            end else if (bc_inc < BC_W'(8)) begin
                                ex_v  = 1'b1;
                                ex_cs = 1'b1;
                                case (bc_inc[2:0])
                                    3'd2:    ex_tx = r_frame[47:40];
                                    3'd3:    ex_tx = r_frame[39:32];
                                    3'd4:    ex_tx = r_frame[31:24];
                                    3'd5:    ex_tx = r_frame[23:16];
                                    3'd6:    ex_tx = r_frame[15:8];
                                    default: ex_tx = r_frame[7:0];
                                endcase
                            end else begin
                                n_phase = PH_POLL; n_bc = '0;
                                ex_v = 1'b1; ex_cs = 1'b1;
                            end
                        end
                        PH_POLL: begin
                            if (i_rx_byte != B_IDLE || r_bc >= BC_W'(r_poll_lim)) begin
                                n_last_r = i_rx_byte;
                                if (is_release) begin
                                    n_phase = PH_REL;
                                    ex_v = 1'b1;
                                end else begin
                                    do_resp = 1'b1;
                                    resp    = i_rx_byte;
                                end
                            end else begin
                                n_bc = bc_inc;
                                ex_v = 1'b1; ex_cs = 1'b1;
                            end
                        end
                        PH_REL: begin
                            do_resp = 1'b1;
                            resp    = r_last_r;
                        end
                        PH_R7: begin
                            n_shift = {r_shift[23:0], i_rx_byte};
                            n_bc    = bc_inc;
                            ex_v    = 1'b1;
                            if (bc_inc < BC_W'(4)) ex_cs = 1'b1;
                            else n_phase = PH_R7REL;
                        end
                        PH_R7REL: begin
                            if (r_which == W_CMD58) begin
                                n_kind = r_shift[30] ? CK_SDHC : CK_SD2;
                                done_v = 1'b1;
                            end else if (r_last_r == R1_IDLE) begin
                                n_retry = 16'd0;
                                do_start = 1'b1; st_which = W_CMD55B; st_idx = 6'd55;
                            end else if (r_last_r == R1_ILL5 || r_last_r == R1_ILL9) begin
                                n_retry = 16'd0;
                                do_start = 1'b1; st_which = W_CMD55A; st_idx = 6'd55;
                            end else begin
                                done_v = 1'b1; done_st = ST_UNKNOWN;
                            end
                        end
                        PH_TOKEN: begin
                            if (i_rx_byte == B_TOKEN) begin
                                n_phase = PH_RDATA; n_bc = '0; n_shift = 32'd0;
                                ex_v = 1'b1; ex_cs = 1'b1;
                            end else if (r_retry >= r_token_lim) begin
                                done_v = 1'b1; done_st = ST_TOKEN_TO;
                            end else begin
                                n_retry = retry_inc[15:0];
                                ex_v = 1'b1; ex_cs = 1'b1;
                            end
                        end
                        PH_RDATA: begin
                            rd_v    = 1'b1;
                            rd_data = i_rx_byte;
                            if (r_which == W_CMD9 && r_bc >= BC_W'(7) && r_bc <= BC_W'(9))
                                n_shift = {r_shift[23:0], i_rx_byte};
                            n_bc = bc_inc;
                            ex_v = 1'b1; ex_cs = 1'b1;
                            if (bc_inc >= ((r_which == W_CMD9) ? CSD_N : BLK_N)) begin
                                n_phase = PH_RCRC; n_bc = '0;
                            end
                        end
                        PH_RCRC: begin
                            n_bc = bc_inc;
                            ex_v = 1'b1;
                            if (bc_inc < BC_W'(2)) ex_cs = 1'b1;
                            else n_phase = PH_FIN;
                        end
                        PH_FIN: begin
                            done_v = 1'b1;
                            if (r_which == W_CMD9) done_cap = {cap_sum, 9'd0};
                        end
                        PH_WPRE: begin
                            n_bc = bc_inc;
                            if (bc_inc < BC_W'(3)) begin
                                ex_v = 1'b1; ex_cs = 1'b1;
                            end else if (bc_inc == BC_W'(3)) begin
                                ex_v = 1'b1; ex_cs = 1'b1; ex_tx = B_TOKEN;
                            end else begin
                                n_phase = PH_WNEED; n_bc = '0; need_v = 1'b1;
                            end
                        end
                        PH_WDATA: begin
                            n_bc = bc_inc;
                            if (bc_inc < BLK_N) begin
                                n_phase = PH_WNEED; need_v = 1'b1;
                            end else begin
                                n_phase = PH_WCRC; n_bc = '0;
                                ex_v = 1'b1; ex_cs = 1'b1;
                            end
                        end
                        PH_WCRC: begin
                            n_bc = bc_inc;
                            ex_v = 1'b1; ex_cs = 1'b1;
                            if (bc_inc >= BC_W'(2)) n_phase = PH_WRESP;
                        end
                        PH_WRESP: begin
                            n_last_r = i_rx_byte;
                            if (i_rx_byte[4:0] != DRESP_OK) begin
                                done_v = 1'b1; done_st = ST_WR_REJ;
                            end else begin
                                n_phase = PH_BUSY; n_retry = 16'd0;
                                ex_v = 1'b1; ex_cs = 1'b1;
                            end
                        end
                        PH_BUSY: begin
                            if (i_rx_byte != 8'd0) begin
                                n_phase = PH_FIN;
                                ex_v = 1'b1;
                            end else if (r_retry >= r_busy_lim) begin
                                done_v = 1'b1; done_st = ST_BUSY_TO;
                            end else begin
                                n_retry = retry_inc[15:0];
                                ex_v = 1'b1; ex_cs = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                C_WBYTE: begin
                    if (r_phase == PH_WNEED) begin
                        n_phase = PH_WDATA;
                        ex_v = 1'b1; ex_cs = 1'b1; ex_tx = i_write_byte;
                    end
                end
                default: ;
            endcase
        end

        // Command response handling.
        if (do_resp) begin
            unique case (r_which)
                W_CMD0: begin
                    if (resp == R1_IDLE) begin
                        do_start = 1'b1; st_which = W_CMD8; st_idx = 6'd8;
                        st_arg = 32'h1AA; st_crc = 8'h87;
                    end else begin
                        n_retry = retry_inc[15:0];
                        if (retry_inc >= {7'd0, r_idle_lim}) begin
                            done_v = 1'b1;
                            done_st = (resp == B_IDLE) ? ST_NO_RESP : ST_R1_ERR;
                        end else begin
                            do_start = 1'b1; st_which = W_CMD0; st_crc = 8'h95;
                        end
                    end
                end
                W_CMD8: begin
                    ex_v = 1'b1;
                    if (resp == R1_IDLE) begin
                        n_phase = PH_R7; n_bc = '0; n_shift = 32'd0; ex_cs = 1'b1;
                    end else begin
                        n_phase = PH_R7REL;
                    end
                end
                W_CMD55A: begin
                    do_start = 1'b1; st_which = W_ACMD41A; st_idx = 6'd41;
                end
                W_ACMD41A: begin
                    if (resp == 8'd0) begin
                        n_kind = CK_SD1; done_v = 1'b1;
                    end else begin
                        n_retry = retry_inc[15:0];
                        do_start = 1'b1;
                        if (retry_inc >= {1'b0, r_opc_lim}) begin
                            n_retry = 16'd0; st_which = W_CMD1; st_idx = 6'd1;
                        end else begin
                            st_which = W_CMD55A; st_idx = 6'd55;
                        end
                    end
                end
                W_CMD1, W_ACMD41B: begin
                    if (resp == 8'd0) begin
                        if (r_which == W_CMD1) begin
                            n_kind = CK_MMC; done_v = 1'b1;
                        end else begin
                            do_start = 1'b1; st_which = W_CMD58; st_idx = 6'd58;
                        end
                    end else begin
                        n_retry = retry_inc[15:0];
                        if (retry_inc >= {1'b0, r_opc_lim}) begin
                            done_v = 1'b1;
                            done_st = (resp == B_IDLE) ? ST_NO_RESP : ST_R1_ERR;
                        end else if (r_which == W_CMD1) begin
                            do_start = 1'b1; st_which = W_CMD1; st_idx = 6'd1;
                        end else begin
                            do_start = 1'b1; st_which = W_CMD55B; st_idx = 6'd55;
                        end
                    end
                end
                W_CMD55B: begin
                    do_start = 1'b1; st_which = W_ACMD41B; st_idx = 6'd41;
                    st_arg = 32'h4000_0000;
                end
                W_CMD58, W_CMD17, W_CMD9, W_CMD24: begin
                    if (resp != 8'd0) begin
                        done_v = 1'b1;
                        done_st = (resp == B_IDLE) ? ST_NO_RESP : ST_R1_ERR;
                    end else begin
                        ex_v = 1'b1; ex_cs = 1'b1;
                        if (r_which == W_CMD58) begin
                            n_phase = PH_R7; n_bc = '0; n_shift = 32'd0;
                        end else if (r_which == W_CMD24) begin
                            n_phase = PH_WPRE; n_bc = '0;
                        end else begin
                            n_phase = PH_TOKEN; n_retry = 16'd0;
                        end
                    end
                end
                default: begin
                    done_v = 1'b1; done_st = ST_R1_ERR;
                end
            endcase
        end

        // Command start: load the frame and send the first idle byte deselected.
        if (do_start) begin
            n_which = st_which;
            n_frame = {2'b01, st_idx, st_arg, st_crc};
            n_phase = PH_CMD;
            n_bc    = '0;
            ex_v    = 1'b1;
            ex_cs   = 1'b0;
            ex_tx   = B_IDLE;
        end
        if (done_v) n_phase = PH_IDLE;
    end

    // Assemble the result beats of this step.
    always_comb begin
        rd_beat             = '0;
        rd_beat.kind        = K_RDATA;
        rd_beat.read_data   = rd_data;
        rd_beat.card_r1     = n_last_r;
        rd_beat.card_kind   = n_kind;
        tail_beat           = '0;
        tail_beat.card_r1   = n_last_r;
        tail_beat.card_kind = n_kind;
        tail_beat.last      = 1'b1;
        if (done_v) begin
            tail_beat.kind        = K_DONE;
            tail_beat.status      = done_st;
            tail_beat.capacity_kb = done_cap;
        end else if (need_v) begin
            tail_beat.kind = K_NEED;
        end else begin
            tail_beat.kind        = K_EXCH;
            tail_beat.tx_byte     = ex_tx;
            tail_beat.chip_select = ex_cs;
        end
        o_res = '0;
        if (rd_v) begin
            o_res.res0  = rd_beat;
            o_res.res1  = tail_beat;
            o_res.count = 2'd2;
        end else if (ex_v || need_v || done_v) begin
            o_res.res0  = tail_beat;
            o_res.count = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_which  <= W_NONE;
            r_bc     <= '0;
            r_retry  <= 16'd0;
            r_shift  <= 32'd0;
            r_kind   <= CK_NONE;
            r_last_r <= 8'hFF;
        end else begin
            r_phase  <= n_phase;
            r_which  <= n_which;
            r_bc     <= n_bc;
            r_retry  <= n_retry;
            r_shift  <= n_shift;
            r_kind   <= n_kind;
            r_last_r <= n_last_r;
        end
    end

    // The command frame is always loaded before it is sent.
    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
    end

    // A step that reads a data byte always follows it with an exchange.
    a_rd_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.count == 2'd2) |-> (o_res.res1.kind == K_EXCH))
        else $error("data byte without following exchange");

    // A completion always returns the engine to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.count == 2'd1 && o_res.res0.kind == K_DONE) |=> (r_phase == PH_IDLE))
        else $error("completion left engine busy");

    // Write data is only requested when the next step waits for it.
    a_need_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.count == 2'd1 && o_res.res0.kind == K_NEED) |=> (r_phase == PH_WNEED))
        else $error("write byte requested outside the wait phase");

endmodule

// File: hdl/sdspi_res_fifo.sv
// Back part: result queue taking up to two beats per cycle and delivering one.
module sdspi_res_fifo #(
    parameter int DEPTH = sdspi_pkg::RES_Q_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sdspi_pkg::t_res_pair i_res,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output sdspi_pkg::t_res      o_head
);
    import sdspi_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_res           r_mem [DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_count;
    logic           pop_ok;
    logic [AW-1:0]  wr1;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count > CW'(DEPTH - 2));
    assign pop_ok  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];
    assign wr1     = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;

    // Pointer and fill-level bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_res.count == 2'd1) r_wr <= wr1;
            else if (i_res.count == 2'd2)
                r_wr <= (wr1 == AW'(DEPTH - 1)) ? '0 : wr1 + 1'b1;
            if (pop_ok) r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            r_count <= r_count + CW'(i_res.count) - CW'(pop_ok);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_res.count != 2'd0) r_mem[r_wr] <= i_res.res0;
        if (i_res.count == 2'd2) r_mem[wr1]  <= i_res.res1;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue overflow");

    a_room_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res.count != 2'd0) |-> (r_count <= CW'(DEPTH - 2)))
        else $error("results written without room");

    a_pop_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_ok && i_res.count == 2'd0) |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not lower the fill level");

endmodule

// File: hdl/sd_spi_mode_host_engine_core.sv
// Top level of the SD card SPI-mode host engine.
//
//  Channel   Handshake            Beat contents
//  --------  -------------------  -----------------------------------------------
//  input     push / full          cmd, request, block_address, rx_byte, write_byte
//  result    empty / pop          kind, tx_byte, chip_select, read_data, status,
//                                 card_r1, card_kind, capacity_kb, last
//  config    i_cfg_we             i_cfg_idx, i_cfg_data (six limit registers)
//
// The protocol step is decided in the accepting cycle, and its one or two results are
// written into a four-entry result queue at that same edge, so a result can be popped
// at the next edge. full rises while the queue has fewer than two free entries. A step
// that reads a data byte gives two results while pop takes one, so even with pop
// held high full stalls a block read; every other step runs one beat per cycle.
// Reset is synchronous and active low; it restores the limit registers to defaults.
module sd_spi_mode_host_engine_core #(
    parameter int BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF,
    parameter int RES_Q_DEPTH = sdspi_pkg::RES_Q_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [1:0]                       i_cmd,
    input  logic [1:0]                       i_request,
    input  logic [31:0]                      i_block_address,
    input  logic [7:0]                       i_rx_byte,
    input  logic [7:0]                       i_write_byte,
    output logic                             empty,
    input  logic                             pop,
    output logic [1:0]                       o_kind,
    output logic [7:0]                       o_tx_byte,
    output logic                             o_chip_select,
    output logic [7:0]                       o_read_data,
    output logic [2:0]                       o_status,
    output logic [7:0]                       o_card_r1,
    output logic [2:0]                       o_card_kind,
    output logic [33:0]                      o_capacity_kb,
    output logic                             o_last,
    input  logic                             i_cfg_we,
    input  logic [sdspi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sdspi_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sdspi_pkg::*;

    t_res_pair res;
    t_res      head;
    logic      accept;

    assign accept = push && !full;

    // Protocol engine.
    sdspi_engine #(.BLOCK_BYTES(BLOCK_BYTES)) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (accept),
        .i_cmd           (i_cmd),
        .i_request       (i_request),
        .i_block_address (i_block_address),
        .i_rx_byte       (i_rx_byte),
        .i_write_byte    (i_write_byte),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_res           (res)
    );

    // Result queue.
    sdspi_res_fifo #(.DEPTH(RES_Q_DEPTH)) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    // Result fields.
    assign o_kind        = head.kind;
    assign o_tx_byte     = head.tx_byte;
    assign o_chip_select = head.chip_select;
    assign o_read_data   = head.read_data;
    assign o_status      = head.status;
    assign o_card_r1     = head.card_r1;
    assign o_card_kind   = head.card_kind;
    assign o_capacity_kb = head.capacity_kb;
    assign o_last        = head.last;

endmodule
